[rtl/kbcs_pkg.sv]
// Shared types and constants for the PS/2 keyboard command sequencer.
// Holds the command, request and result codes, the keyboard byte values and the result record.
// No dependencies.
package kbcs_pkg;

  localparam int unsigned QueueDepthDefault = 16;
  localparam int unsigned PortCountDefault  = 2;
  localparam int unsigned MaxResults        = 3;

  typedef enum logic [1:0] {
    CMD_ENQUEUE = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_CONNECT = 2'd2
  } cmd_e;

  typedef enum logic [1:0] {
    REQ_ECHO    = 2'd0,
    REQ_ENABLE  = 2'd1,
    REQ_DISABLE = 2'd2,
    REQ_GETSET  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    RES_DONE    = 3'd0,
    RES_TX      = 3'd1,
    RES_PASS    = 3'd2,
    RES_ECHO_OK = 3'd3,
    RES_SET     = 3'd4,
    RES_FULL    = 3'd5
  } res_kind_e;

  localparam logic [7:0] BYTE_RESEND     = 8'hFE;
  localparam logic [7:0] BYTE_ACK        = 8'hFA;
  localparam logic [7:0] BYTE_ECHO       = 8'hEE;
  localparam logic [7:0] BYTE_ENABLE     = 8'hF4;
  localparam logic [7:0] BYTE_DISABLE    = 8'hF5;
  localparam logic [7:0] BYTE_GETSET     = 8'hF0;
  localparam logic [7:0] BYTE_GETSET_ARG = 8'h00;

  typedef struct packed {
    res_kind_e  kind;
    logic       port;
    logic [7:0] data;
  } res_t;

  // Results appended to the output buffer in the same cycle, and the start of delivery.
  typedef struct packed {
    logic [1:0] cnt;
    res_t       first;
    res_t       second;
    logic       send;
  } buf_ctl_t;

  function automatic logic [7:0] tx_byte(req_e kind);
    logic [7:0] b;
    case (kind)
      REQ_ECHO:    b = BYTE_ECHO;
      REQ_ENABLE:  b = BYTE_ENABLE;
      REQ_DISABLE: b = BYTE_DISABLE;
      default:     b = BYTE_GETSET;
    endcase
    return b;
  endfunction

endpackage

[rtl/kbcs_cmd_ram.sv]
// Command queue storage for all ports, one 2-bit command code per entry.
// Synchronous memory with one write port and one registered read port.
// Uses no package.
module kbcs_cmd_ram #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned AW    = 5
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [1:0]    wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic [1:0]    rdata_o
);

  logic [1:0] mem_q [DEPTH];
  logic [1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/kbcs_stat_ram.sv]
// Per-port status storage: queue pointers, reply tracking and learned scancode set.
// Synchronous memory with a registered read; entries read as zero until first written.
// Uses no package.
module kbcs_stat_ram #(
  parameter int unsigned ENTRIES = 2,
  parameter int unsigned W       = 20,
  parameter int unsigned IW      = 1
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          we_i,
  input  logic [IW-1:0] waddr_i,
  input  logic [W-1:0]  wdata_i,
  input  logic          re_i,
  input  logic [IW-1:0] raddr_i,
  output logic [W-1:0]  rdata_o
);

  logic [W-1:0] mem_q [ENTRIES];
  logic         valid_q [ENTRIES];
  logic [W-1:0] data_q;
  logic         rvalid_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      data_q <= mem_q[raddr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < ENTRIES; i++) begin
        valid_q[i] <= 1'b0;
      end
      rvalid_q <= 1'b0;
    end else begin
      if (we_i) begin
        valid_q[waddr_i] <= 1'b1;
      end
      if (re_i) begin
        rvalid_q <= valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rvalid_q ? data_q : '0;

endmodule

[rtl/kbcs_out_buf.sv]
// Result buffer and output stage: collects up to three results of one item and
// delivers them one transfer per cycle while the output side is ready, marking the final one.
// Depends on kbcs_pkg.
module kbcs_out_buf (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  kbcs_pkg::buf_ctl_t ctl_i,
  output logic               busy_o,
  output logic               m_valid_o,
  input  logic               m_ready_i,
  output kbcs_pkg::res_t     res_o,
  output logic               last_o
);

  kbcs_pkg::res_t res_q [kbcs_pkg::MaxResults];
  kbcs_pkg::res_t res_d [kbcs_pkg::MaxResults];
  logic [1:0]     n_q, n_d;
  logic [1:0]     idx_q, idx_d;
  logic           busy_q, busy_d;
  logic           last;

  assign last = (idx_q == (n_q - 2'd1));

  always_comb begin
    res_d  = res_q;
    n_d    = n_q + ctl_i.cnt;
    idx_d  = idx_q;
    busy_d = busy_q;
    if ((ctl_i.cnt != 2'd0) && (n_q < 2'(kbcs_pkg::MaxResults))) begin
      res_d[n_q] = ctl_i.first;
    end
    if ((ctl_i.cnt == 2'd2) && (n_q < 2'(kbcs_pkg::MaxResults - 1))) begin
      res_d[n_q + 2'd1] = ctl_i.second;
    end
    if (ctl_i.send) begin
      busy_d = 1'b1;
      idx_d  = 2'd0;
    end
    if (busy_q && m_ready_i) begin
      if (last) begin
        busy_d = 1'b0;
        n_d    = 2'd0;
        idx_d  = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_q    <= 2'd0;
      idx_q  <= 2'd0;
      busy_q <= 1'b0;
    end else begin
      n_q    <= n_d;
      idx_q  <= idx_d;
      busy_q <= busy_d;
    end
  end

  assign busy_o    = busy_q;
  assign m_valid_o = busy_q;
  assign res_o     = res_q[idx_q];
  assign last_o    = last;

endmodule

[rtl/ps2_keyboard_command_sequencer.sv]
// Host-side PS/2 keyboard command sequencer for up to two ports. Each port keeps a queue of
// keyboard commands (echo, enable, disable, get scancode set) in a shared command memory and
// its pointers and reply state in a status memory; every item reads the port's status,
// reads or writes the queue as needed, writes the status back as needed and then delivers its
// one or two results. Items are handled one at a time: after acceptance the status read is
// evaluated, then each queue entry is written in turn (enqueue and connect), or a reply reads
// the queue head and, when it pops the head and the next command is sent, the next entry;
// each result is transferred while the output side is ready, and the next item is accepted
// only after the last result. Depends on kbcs_pkg, kbcs_cmd_ram, kbcs_stat_ram and kbcs_out_buf.
module ps2_keyboard_command_sequencer #(
  parameter int unsigned QUEUE_DEPTH = kbcs_pkg::QueueDepthDefault,
  parameter int unsigned PORT_COUNT  = kbcs_pkg::PortCountDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [15:0] s_axis_tdata,  // request_kind [1:0], rx_byte [9:2], zero fill
  input  logic [2:0]  s_axis_tuser,  // command [1:0], port [2]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,  // data_byte [7:0]
  output logic [3:0]  m_axis_tuser,  // result_kind [2:0], result_port [3]
  output logic        m_axis_tlast
);

  localparam int unsigned QW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned TW = CW + 1;
  localparam int unsigned AW = $clog2(PORT_COUNT * QUEUE_DEPTH);
  localparam int unsigned PW = (PORT_COUNT > 1) ? $clog2(PORT_COUNT) : 1;
  localparam int unsigned SW = QW + CW + 11;
  localparam logic [QW-1:0] LastIdx = QW'(QUEUE_DEPTH - 1);
  localparam logic PortOneOk = (PORT_COUNT > 1);

  typedef struct packed {
    logic [QW-1:0] head;
    logic [CW-1:0] count;
    logic          awaiting;
    logic          progress;
    logic [7:0]    learned;
    logic          set_unknown;
  } stat_t;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_STAT  = 6'b000010,
    S_PUSH  = 6'b000100,
    S_HEAD  = 6'b001000,
    S_NEXT  = 6'b010000,
    S_DRAIN = 6'b100000
  } state_e;

  function automatic logic [QW-1:0] wrap_inc(logic [QW-1:0] idx);
    return (idx == LastIdx) ? '0 : idx + 1'b1;
  endfunction

  function automatic logic [AW-1:0] queue_addr(logic p, logic [QW-1:0] idx);
    return AW'(AW'(p) * AW'(QUEUE_DEPTH)) + AW'(idx);
  endfunction

  function automatic kbcs_pkg::buf_ctl_t one_res(kbcs_pkg::res_kind_e k, logic p,
                                                 logic [7:0] d);
    kbcs_pkg::buf_ctl_t c;
    c = '0;
    c.cnt        = 2'd1;
    c.first.kind = k;
    c.first.port = p;
    c.first.data = d;
    return c;
  endfunction

  function automatic kbcs_pkg::buf_ctl_t tx_res(kbcs_pkg::req_e k, logic p);
    kbcs_pkg::buf_ctl_t c;
    c = '0;
    c.cnt         = (k == kbcs_pkg::REQ_GETSET) ? 2'd2 : 2'd1;
    c.first.kind  = kbcs_pkg::RES_TX;
    c.first.port  = p;
    c.first.data  = kbcs_pkg::tx_byte(k);
    c.second.kind = kbcs_pkg::RES_TX;
    c.second.port = p;
    c.second.data = kbcs_pkg::BYTE_GETSET_ARG;
    return c;
  endfunction

  state_e        state_q, state_d;
  logic [1:0]    cmd_q, cmd_d;
  logic          port_q, port_d;
  logic [1:0]    kind_q, kind_d;
  logic [7:0]    byte_q, byte_d;
  stat_t         st_q, st_d;
  logic [QW-1:0] tail_q, tail_d;
  logic [1:0]    push_left_q, push_left_d;

  logic          stat_we, stat_re;
  logic [PW-1:0] stat_waddr, stat_raddr;
  logic [SW-1:0] stat_wdata, stat_rdata;
  logic          cmd_we, cmd_re;
  logic [AW-1:0] cmd_waddr, cmd_raddr;
  logic [1:0]    cmd_wdata, cmd_rdata;

  stat_t              st_rd, st_new;
  kbcs_pkg::buf_ctl_t ctl;
  logic               buf_busy;
  kbcs_pkg::res_t     out_res;
  kbcs_pkg::req_e     head_kind;
  logic               triple, port_ok, pop, ack_pop, full;
  logic [1:0]         need;
  logic [TW-1:0]      tail_sum;
  logic [QW-1:0]      tail_start;
  kbcs_pkg::req_e     first_kind, push_kind;

  assign st_rd      = stat_rdata;
  assign head_kind  = kbcs_pkg::req_e'(cmd_rdata);
  assign triple     = (cmd_q == kbcs_pkg::CMD_CONNECT) || (kind_q == kbcs_pkg::REQ_GETSET);
  assign port_ok    = PortOneOk || !port_q;
  assign need       = triple ? 2'd3 : 2'd1;
  assign full       = ({1'b0, st_rd.count} + TW'(need)) > TW'(QUEUE_DEPTH);
  assign tail_sum   = TW'(st_rd.head) + TW'(st_rd.count);
  assign tail_start = (tail_sum >= TW'(QUEUE_DEPTH)) ? QW'(tail_sum - TW'(QUEUE_DEPTH))
                                                     : QW'(tail_sum);
  assign first_kind = triple ? kbcs_pkg::REQ_DISABLE : kbcs_pkg::req_e'(kind_q);

  always_comb begin
    if (!triple) begin
      push_kind = kbcs_pkg::req_e'(kind_q);
    end else begin
      case (push_left_q)
        2'd3:    push_kind = kbcs_pkg::REQ_DISABLE;
        2'd2:    push_kind = kbcs_pkg::REQ_GETSET;
        default: push_kind = kbcs_pkg::REQ_ENABLE;
      endcase
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_d       = cmd_q;
    port_d      = port_q;
    kind_d      = kind_q;
    byte_d      = byte_q;
    st_d        = st_q;
    tail_d      = tail_q;
    push_left_d = push_left_q;
    stat_re     = 1'b0;
    stat_raddr  = PW'(s_axis_tuser[2]);
    stat_we     = 1'b0;
    stat_waddr  = PW'(port_q);
    cmd_re      = 1'b0;
    cmd_raddr   = queue_addr(port_q, st_rd.head);
    cmd_we      = 1'b0;
    cmd_waddr   = queue_addr(port_q, tail_q);
    cmd_wdata   = push_kind;
    ctl         = '0;
    st_new      = st_rd;
    pop         = 1'b0;
    ack_pop     = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d   = s_axis_tuser[1:0];
          port_d  = s_axis_tuser[2];
          kind_d  = s_axis_tdata[1:0];
          byte_d  = s_axis_tdata[9:2];
          stat_re = 1'b1;
          state_d = S_STAT;
        end
      end

      S_STAT: begin
        state_d = S_DRAIN;
        if (!port_ok) begin
          ctl      = one_res(kbcs_pkg::RES_DONE, port_q, 8'h00);
          ctl.send = 1'b1;
        end else begin
          case (cmd_q)
            kbcs_pkg::CMD_ENQUEUE: begin
              if (full) begin
                ctl      = one_res(kbcs_pkg::RES_FULL, port_q, 8'h00);
                ctl.send = 1'b1;
              end else begin
                st_new.count = st_rd.count + CW'(need);
                if (st_rd.count == '0) begin
                  st_new.awaiting = 1'b1;
                  st_new.progress = 1'b0;
                  ctl = tx_res(first_kind, port_q);
                end else begin
                  ctl = one_res(kbcs_pkg::RES_DONE, port_q, 8'h00);
                end
                stat_we     = 1'b1;
                tail_d      = tail_start;
                push_left_d = need;
                state_d     = S_PUSH;
              end
            end
            kbcs_pkg::CMD_CONNECT: begin
              st_new.head        = '0;
              st_new.count       = CW'(3);
              st_new.awaiting    = 1'b1;
              st_new.progress    = 1'b0;
              st_new.set_unknown = 1'b1;
              ctl         = tx_res(kbcs_pkg::REQ_DISABLE, port_q);
              stat_we     = 1'b1;
              tail_d      = '0;
              push_left_d = 2'd3;
              state_d     = S_PUSH;
            end
            kbcs_pkg::CMD_RX_BYTE: begin
              if ((st_rd.count != '0) && st_rd.awaiting) begin
                cmd_re  = 1'b1;
                st_d    = st_rd;
                state_d = S_HEAD;
              end else begin
                ctl      = one_res(kbcs_pkg::RES_PASS, port_q, byte_q);
                ctl.send = 1'b1;
              end
            end
            default: begin
              ctl      = one_res(kbcs_pkg::RES_DONE, port_q, 8'h00);
              ctl.send = 1'b1;
            end
          endcase
        end
      end

      S_PUSH: begin
        cmd_we      = 1'b1;
        tail_d      = wrap_inc(tail_q);
        push_left_d = push_left_q - 2'd1;
        if (push_left_q == 2'd1) begin
          ctl.send = 1'b1;
          state_d  = S_DRAIN;
        end
      end

      S_HEAD: begin
        st_new = st_q;
        if ((head_kind == kbcs_pkg::REQ_GETSET) && st_q.progress) begin
          st_new.learned     = byte_q - 8'd1;
          st_new.set_unknown = 1'b0;
          ctl = one_res(kbcs_pkg::RES_SET, port_q, byte_q - 8'd1);
          pop = 1'b1;
        end else if (byte_q == kbcs_pkg::BYTE_RESEND) begin
          ctl = tx_res(head_kind, port_q);
        end else if (head_kind == kbcs_pkg::REQ_ECHO) begin
          if (byte_q == kbcs_pkg::BYTE_ECHO) begin
            ctl = one_res(kbcs_pkg::RES_ECHO_OK, port_q, 8'h00);
            pop = 1'b1;
          end else begin
            ctl = one_res(kbcs_pkg::RES_PASS, port_q, byte_q);
          end
        end else if (byte_q == kbcs_pkg::BYTE_ACK) begin
          if (head_kind == kbcs_pkg::REQ_GETSET) begin
            st_new.progress = 1'b1;
            ctl = one_res(kbcs_pkg::RES_DONE, port_q, 8'h00);
          end else begin
            pop     = 1'b1;
            ack_pop = 1'b1;
          end
        end else begin
          ctl = one_res(kbcs_pkg::RES_PASS, port_q, byte_q);
        end

        if (pop) begin
          st_new.head     = wrap_inc(st_q.head);
          st_new.count    = st_q.count - CW'(1);
          st_new.progress = 1'b0;
          st_new.awaiting = (st_q.count != CW'(1));
        end
        stat_we = 1'b1;
        st_d    = st_new;

        if (pop && (st_q.count != CW'(1))) begin
          cmd_re    = 1'b1;
          cmd_raddr = queue_addr(port_q, wrap_inc(st_q.head));
          state_d   = S_NEXT;
        end else begin
          if (ack_pop) begin
            ctl = one_res(kbcs_pkg::RES_DONE, port_q, 8'h00);
          end
          ctl.send = 1'b1;
          state_d  = S_DRAIN;
        end
      end

      S_NEXT: begin
        ctl      = tx_res(head_kind, port_q);
        ctl.send = 1'b1;
        state_d  = S_DRAIN;
      end

      S_DRAIN: begin
        if (!buf_busy) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  assign stat_wdata = st_new;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    port_q      <= port_d;
    kind_q      <= kind_d;
    byte_q      <= byte_d;
    st_q        <= st_d;
    tail_q      <= tail_d;
    push_left_q <= push_left_d;
  end

  kbcs_stat_ram #(
    .ENTRIES(PORT_COUNT),
    .W      (SW),
    .IW     (PW)
  ) u_stat_ram (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .we_i   (stat_we),
    .waddr_i(stat_waddr),
    .wdata_i(stat_wdata),
    .re_i   (stat_re),
    .raddr_i(stat_raddr),
    .rdata_o(stat_rdata)
  );

  kbcs_cmd_ram #(
    .DEPTH(PORT_COUNT * QUEUE_DEPTH),
    .AW   (AW)
  ) u_cmd_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_we),
    .waddr_i(cmd_waddr),
    .wdata_i(cmd_wdata),
    .re_i   (cmd_re),
    .raddr_i(cmd_raddr),
    .rdata_o(cmd_rdata)
  );

  kbcs_out_buf u_out_buf (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctl_i    (ctl),
    .busy_o   (buf_busy),
    .m_valid_o(m_axis_tvalid),
    .m_ready_i(m_axis_tready),
    .res_o    (out_res),
    .last_o   (m_axis_tlast)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tdata  = out_res.data;
  assign m_axis_tuser  = {out_res.port, out_res.kind};

endmodule

[rtl/kbcs_checker.sv]
// Port-level checks for the PS/2 keyboard command sequencer, bound to its top level.
// Depends on kbcs_pkg and ps2_keyboard_command_sequencer.
module kbcs_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       s_axis_tvalid,
  input logic       s_axis_tready,
  input logic       m_axis_tvalid,
  input logic       m_axis_tready,
  input logic [7:0] m_axis_tdata,
  input logic [3:0] m_axis_tuser,
  input logic       m_axis_tlast
);

  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s_axis_tready && m_axis_tvalid))
    else $error("input accepted while results are pending");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("ready stayed high after an input transfer");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) &&
       $stable(m_axis_tlast)))
    else $error("stalled result changed");

  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser[2:0] == kbcs_pkg::RES_DONE) ||
                       (m_axis_tuser[2:0] == kbcs_pkg::RES_FULL))) |-> m_axis_tlast)
    else $error("done or queue full result was not the only result");

  a_zero_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && ((m_axis_tuser[2:0] == kbcs_pkg::RES_DONE) ||
                       (m_axis_tuser[2:0] == kbcs_pkg::RES_ECHO_OK) ||
                       (m_axis_tuser[2:0] == kbcs_pkg::RES_FULL))) |->
      (m_axis_tdata == 8'h00))
    else $error("result without data carried a nonzero byte");

endmodule

bind ps2_keyboard_command_sequencer kbcs_checker u_kbcs_checker (.*);
